// File: sv/rist_pkg.sv
// Shared types and constants for the interrupt select and trap entry block.
`default_nettype none

package rist_pkg;

  localparam int unsigned XLEN   = 64;
  localparam int unsigned PEND_W = 12;
  localparam int unsigned CAUSE_W = 4;

  // Privilege mode codes
  localparam logic [1:0] MODE_USER    = 2'd0;
  localparam logic [1:0] MODE_SUPER   = 2'd1;
  localparam logic [1:0] MODE_MACHINE = 2'd3;

  // Selectable interrupt causes
  localparam logic [CAUSE_W-1:0] CAUSE_SSI = 4'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_MSI = 4'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_STI = 4'd5;
  localparam logic [CAUSE_W-1:0] CAUSE_MTI = 4'd7;
  localparam logic [CAUSE_W-1:0] CAUSE_SEI = 4'd9;
  localparam logic [CAUSE_W-1:0] CAUSE_MEI = 4'd11;

  // Configuration register indexes
  localparam logic [1:0] REG_ENABLE_MASK   = 2'd0;
  localparam logic [1:0] REG_DELEGATE_MASK = 2'd1;
  localparam logic [1:0] REG_MACHINE_VEC   = 2'd2;
  localparam logic [1:0] REG_SUPER_VEC     = 2'd3;

  // Outcome of the priority select
  typedef struct packed {
    logic               found;
    logic [CAUSE_W-1:0] cause;
  } sel_t;

  // One result item
  typedef struct packed {
    logic               trap_taken;
    logic [CAUSE_W-1:0] cause_code;
    logic               to_supervisor;
    logic [XLEN-1:0]    target_pc;
    logic [1:0]         new_priv;
    logic [XLEN-1:0]    saved_pc;
    logic               saved_prev_enable;
    logic [1:0]         saved_prev_priv;
  } result_t;

endpackage

`default_nettype wire

// File: sv/rist_select.sv
// Pending update, global enable gate and fixed priority interrupt select.
`default_nettype none

module rist_select
  import rist_pkg::*;
(
  input  wire logic [PEND_W-1:0] pending,
  input  wire logic [PEND_W-1:0] raise_lines,
  input  wire logic              device_request,
  input  wire logic [1:0]        mode,
  input  wire logic              asleep,
  input  wire logic              mgie,
  input  wire logic              sgie,
  input  wire logic [PEND_W-1:0] enable_mask,
  output logic      [PEND_W-1:0] pending_next,
  output sel_t                   sel
);

  logic              gated;
  logic [PEND_W-1:0] raised;
  logic [PEND_W-1:0] with_dev;
  logic [PEND_W-1:0] active;
  logic [PEND_W-1:0] clear_bit;

  // Gate on the global enable of the current mode unless asleep
  always_comb begin
    gated = 1'b0;
    if (mode == MODE_MACHINE && !mgie && !asleep) begin
      gated = 1'b1;
    end
    if (mode == MODE_SUPER && !sgie && !asleep) begin
      gated = 1'b1;
    end
  end

  assign raised   = pending | raise_lines;
  assign with_dev = raised | (device_request ? (PEND_W'(1) << CAUSE_SEI) : '0);
  assign active   = with_dev & enable_mask;

  // Fixed priority: MEI, MSI, MTI, SEI, SSI, STI
  always_comb begin
    sel.found = 1'b1;
    sel.cause = '0;
    if (gated) begin
      sel.found = 1'b0;
    end else if (active[CAUSE_MEI]) begin
      sel.cause = CAUSE_MEI;
    end else if (active[CAUSE_MSI]) begin
      sel.cause = CAUSE_MSI;
    end else if (active[CAUSE_MTI]) begin
      sel.cause = CAUSE_MTI;
    end else if (active[CAUSE_SEI]) begin
      sel.cause = CAUSE_SEI;
    end else if (active[CAUSE_SSI]) begin
      sel.cause = CAUSE_SSI;
    end else if (active[CAUSE_STI]) begin
      sel.cause = CAUSE_STI;
    end else begin
      sel.found = 1'b0;
    end
  end

  // Drop the winning bit; a gated check keeps the pending and raised bits but drops the device request
  assign clear_bit    = sel.found ? (PEND_W'(1) << sel.cause) : '0;
  assign pending_next = gated ? raised : (with_dev & ~clear_bit);

endmodule

`default_nettype wire

// File: sv/rist_entry.sv
// Trap entry: target mode, vector address and saved status for a selected cause.
`default_nettype none

module rist_entry
  import rist_pkg::*;
(
  input  wire sel_t             sel,
  input  wire logic [1:0]       mode,
  input  wire logic             mgie,
  input  wire logic             sgie,
  input  wire logic [XLEN-1:0]  pc,
  input  wire logic [PEND_W-1:0] delegate_mask,
  input  wire logic [XLEN-1:0]  machine_vector,
  input  wire logic [XLEN-1:0]  supervisor_vector,
  output result_t               res
);

  logic            deleg;
  logic            to_s;
  logic [XLEN-1:0] base;
  logic [XLEN-1:0] offset;

  // Machine timer is never delegated
  assign deleg  = delegate_mask[sel.cause] && (sel.cause != CAUSE_MTI);
  assign to_s   = deleg && (mode == MODE_USER || mode == MODE_SUPER);
  assign base   = to_s ? supervisor_vector : machine_vector;
  assign offset = base[0] ? {{(XLEN-CAUSE_W-2){1'b0}}, sel.cause, 2'b00} : '0;

  // Zero every field when no trap is taken
  always_comb begin
    res = '0;
    if (sel.found) begin
      res.trap_taken        = 1'b1;
      res.cause_code        = sel.cause;
      res.to_supervisor     = to_s;
      res.target_pc         = {base[XLEN-1:2], 2'b00} + offset;
      res.new_priv          = to_s ? MODE_SUPER : MODE_MACHINE;
      res.saved_pc          = {pc[XLEN-1:1], 1'b0};
      res.saved_prev_enable = to_s ? sgie : mgie;
      res.saved_prev_priv   = mode;
    end
  end

endmodule

`default_nettype wire

// File: sv/riscv_interrupt_select_and_trap_entry.sv
// Interrupt select and trap entry top level: input register, select, result register.
// Path from input accept to result accept: input register, then result register;
// out_valid rises as the item moves from the input register to the result register.
// Throughput: one item per cycle while out_stall is low; each item reads and updates
// the pending store, so the next item sees the store left by the item ahead of it.
// Reset clears the pending store, all configuration registers and both valid flags.
`default_nettype none

module riscv_interrupt_select_and_trap_entry
  import rist_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration write port
  input  wire logic              config_write,
  input  wire logic [1:0]        config_index,
  input  wire logic [XLEN-1:0]   config_data,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [XLEN-1:0]   current_pc,
  input  wire logic [1:0]        priv_mode,
  input  wire logic              asleep,
  input  wire logic              machine_global_enable,
  input  wire logic              supervisor_global_enable,
  input  wire logic [PEND_W-1:0] raise_lines,
  input  wire logic              device_request,
  // output channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   trap_taken,
  output logic [CAUSE_W-1:0]     cause_code,
  output logic                   to_supervisor,
  output logic [XLEN-1:0]        target_pc,
  output logic [1:0]             new_priv,
  output logic [XLEN-1:0]        saved_pc,
  output logic                   saved_prev_enable,
  output logic [1:0]             saved_prev_priv
);

  logic [PEND_W-1:0] enable_mask;
  logic [PEND_W-1:0] delegate_mask;
  logic [XLEN-1:0]   machine_vector;
  logic [XLEN-1:0]   supervisor_vector;
  logic [PEND_W-1:0] pending;
  logic [PEND_W-1:0] pending_next;

  logic              s1_valid;
  logic [XLEN-1:0]   s1_pc;
  logic [1:0]        s1_mode;
  logic              s1_asleep;
  logic              s1_mgie;
  logic              s1_sgie;
  logic [PEND_W-1:0] s1_raise;
  logic              s1_dev;

  logic              s1_move;
  logic              in_take;
  sel_t              sel;
  result_t           res_next;
  result_t           res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask       <= '0;
      delegate_mask     <= '0;
      machine_vector    <= '0;
      supervisor_vector <= '0;
    end else if (config_write) begin
      case (config_index)
        REG_ENABLE_MASK:   enable_mask       <= config_data[PEND_W-1:0];
        REG_DELEGATE_MASK: delegate_mask     <= config_data[PEND_W-1:0];
        REG_MACHINE_VEC:   machine_vector    <= config_data;
        REG_SUPER_VEC:     supervisor_vector <= config_data;
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 advances when the result register is free or draining
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pc     <= current_pc;
      s1_mode   <= priv_mode;
      s1_asleep <= asleep;
      s1_mgie   <= machine_global_enable;
      s1_sgie   <= supervisor_global_enable;
      s1_raise  <= raise_lines;
      s1_dev    <= device_request;
    end
  end

  rist_select u_select (
    .pending        (pending),
    .raise_lines    (s1_raise),
    .device_request (s1_dev),
    .mode           (s1_mode),
    .asleep         (s1_asleep),
    .mgie           (s1_mgie),
    .sgie           (s1_sgie),
    .enable_mask    (enable_mask),
    .pending_next   (pending_next),
    .sel            (sel)
  );

  rist_entry u_entry (
    .sel               (sel),
    .mode              (s1_mode),
    .mgie              (s1_mgie),
    .sgie              (s1_sgie),
    .pc                (s1_pc),
    .delegate_mask     (delegate_mask),
    .machine_vector    (machine_vector),
    .supervisor_vector (supervisor_vector),
    .res               (res_next)
  );

  // Pending store advances once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (s1_move) begin
      pending <= pending_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res <= res_next;
    end
  end

  assign trap_taken        = res.trap_taken;
  assign cause_code        = res.cause_code;
  assign to_supervisor     = res.to_supervisor;
  assign target_pc         = res.target_pc;
  assign new_priv          = res.new_priv;
  assign saved_pc          = res.saved_pc;
  assign saved_prev_enable = res.saved_prev_enable;
  assign saved_prev_priv   = res.saved_prev_priv;

  // The input side only stalls while an item sits in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // The winning pending bit is gone after the item moves on
  a_winner_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_move && sel.found) |=> (pending[$past(sel.cause)] == 1'b0))
    else $error("selected pending bit not cleared");

  // A result without a trap carries all-zero fields
  a_no_trap_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !trap_taken) |->
      (cause_code == '0 && target_pc == '0 && saved_pc == '0 && new_priv == '0))
    else $error("no-trap result has nonzero fields");

  // Target mode and new privilege agree
  a_priv_matches: assert property (@(posedge clk) disable iff (rst)
    (out_valid && trap_taken) |->
      (new_priv == (to_supervisor ? MODE_SUPER : MODE_MACHINE)))
    else $error("new privilege disagrees with trap target");

endmodule

`default_nettype wire

// File: bench/riscv_interrupt_select_and_trap_entry_tb.sv
// Self-checking bench for the interrupt select and trap entry block.
`timescale 1ns / 100ps

module riscv_interrupt_select_and_trap_entry_tb;
  import rist_pkg::*;

  // Reserved privilege encoding; the package names only the legal modes
  localparam logic [1:0] MODE_RESERVED = 2'd2;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 140;

  // One check event as seen on the input channel
  typedef struct packed {
    logic [XLEN-1:0]   pc;
    logic [1:0]        mode;
    logic              sleep;
    logic              mgie;
    logic              sgie;
    logic [PEND_W-1:0] raise;
    logic              dev;
  } check_event_t;

  // Trap predictor plus the queue of trap results still owed by the block
  class trap_scoreboard;
    logic [PEND_W-1:0] pending;
    logic [PEND_W-1:0] enable_mask;
    logic [PEND_W-1:0] delegate_mask;
    logic [XLEN-1:0]   machine_vec;
    logic [XLEN-1:0]   super_vec;
    result_t           expected_traps[$];
    int unsigned       events_seen;
    int unsigned       traps_seen;
    int unsigned       super_traps;
    int unsigned       failures;

    function new();
      pending = '0;
      enable_mask = '0;
      delegate_mask = '0;
      machine_vec = '0;
      super_vec = '0;
      events_seen = 0;
      traps_seen = 0;
      super_traps = 0;
      failures = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [XLEN-1:0] value);
      case (index)
        REG_ENABLE_MASK:   enable_mask = value[PEND_W-1:0];
        REG_DELEGATE_MASK: delegate_mask = value[PEND_W-1:0];
        REG_MACHINE_VEC:   machine_vec = value;
        REG_SUPER_VEC:     super_vec = value;
        default: ;
      endcase
    endfunction

    // Update the pending store and queue the trap this event should cause
    function void log_check_event(check_event_t ev);
      result_t            r;
      logic [PEND_W-1:0]  active;
      logic [CAUSE_W-1:0] cause;
      logic [CAUSE_W-1:0] order[6];
      logic               found;
      logic               blocked;
      logic               to_s;
      logic [XLEN-1:0]    base;
      order = '{CAUSE_MEI, CAUSE_MSI, CAUSE_MTI, CAUSE_SEI, CAUSE_SSI, CAUSE_STI};
      r = '0;
      found = 1'b0;
      cause = '0;
      events_seen++;
      pending = pending | ev.raise;
      blocked = !ev.sleep && ((ev.mode == MODE_MACHINE && !ev.mgie) ||
                              (ev.mode == MODE_SUPER && !ev.sgie));
      if (!blocked) begin
        if (ev.dev) pending[CAUSE_SEI] = 1'b1;
        active = pending & enable_mask;
        foreach (order[i]) begin
          if (!found && active[order[i]]) begin
            found = 1'b1;
            cause = order[i];
          end
        end
        if (found) begin
          pending[cause] = 1'b0;
          to_s = delegate_mask[cause] && cause != CAUSE_MTI &&
                 (ev.mode == MODE_USER || ev.mode == MODE_SUPER);
          base = to_s ? super_vec : machine_vec;
          r.trap_taken = 1'b1;
          r.cause_code = cause;
          r.to_supervisor = to_s;
          r.target_pc = {base[XLEN-1:2], 2'b00} +
                        (base[0] ? {{(XLEN-CAUSE_W){1'b0}}, cause} << 2 : '0);
          r.new_priv = to_s ? MODE_SUPER : MODE_MACHINE;
          r.saved_pc = {ev.pc[XLEN-1:1], 1'b0};
          r.saved_prev_enable = to_s ? ev.sgie : ev.mgie;
          r.saved_prev_priv = ev.mode;
        end
      end
      expected_traps.push_back(r);
    endfunction

    function void report_failure(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function void compare_field(string name, logic [XLEN-1:0] exp_v, logic [XLEN-1:0] act_v);
      if (act_v !== exp_v)
        report_failure($sformatf("%s expected %h actual %h", name, exp_v, act_v));
    endfunction

    // Match one result item against the oldest expected trap
    function void check_trap_result(result_t act);
      result_t exp_r;
      if (expected_traps.size() == 0) begin
        report_failure("result item with no check event outstanding");
        return;
      end
      exp_r = expected_traps.pop_front();
      if (exp_r.trap_taken) traps_seen++;
      if (exp_r.to_supervisor) super_traps++;
      compare_field("trap_taken", XLEN'(exp_r.trap_taken), XLEN'(act.trap_taken));
      compare_field("cause_code", XLEN'(exp_r.cause_code), XLEN'(act.cause_code));
      compare_field("to_supervisor", XLEN'(exp_r.to_supervisor),
                    XLEN'(act.to_supervisor));
      compare_field("target_pc", exp_r.target_pc, act.target_pc);
      compare_field("new_priv", XLEN'(exp_r.new_priv), XLEN'(act.new_priv));
      compare_field("saved_pc", exp_r.saved_pc, act.saved_pc);
      compare_field("saved_prev_enable", XLEN'(exp_r.saved_prev_enable),
                    XLEN'(act.saved_prev_enable));
      compare_field("saved_prev_priv", XLEN'(exp_r.saved_prev_priv),
                    XLEN'(act.saved_prev_priv));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              config_write = 1'b0;
  logic [1:0]        config_index = REG_ENABLE_MASK;
  logic [XLEN-1:0]   config_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [XLEN-1:0]   current_pc = '0;
  logic [1:0]        priv_mode = MODE_USER;
  logic              asleep = 1'b0;
  logic              machine_global_enable = 1'b0;
  logic              supervisor_global_enable = 1'b0;
  logic [PEND_W-1:0] raise_lines = '0;
  logic              device_request = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              trap_taken;
  logic [CAUSE_W-1:0] cause_code;
  logic              to_supervisor;
  logic [XLEN-1:0]   target_pc;
  logic [1:0]        new_priv;
  logic [XLEN-1:0]   saved_pc;
  logic              saved_prev_enable;
  logic [1:0]        saved_prev_priv;

  trap_scoreboard trap_board = new();

  riscv_interrupt_select_and_trap_entry u_top (
    .clk                      (clk),
    .rst                      (rst),
    .config_write             (config_write),
    .config_index             (config_index),
    .config_data              (config_data),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .current_pc               (current_pc),
    .priv_mode                (priv_mode),
    .asleep                   (asleep),
    .machine_global_enable    (machine_global_enable),
    .supervisor_global_enable (supervisor_global_enable),
    .raise_lines              (raise_lines),
    .device_request           (device_request),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .trap_taken               (trap_taken),
    .cause_code               (cause_code),
    .to_supervisor            (to_supervisor),
    .target_pc                (target_pc),
    .new_priv                 (new_priv),
    .saved_pc                 (saved_pc),
    .saved_prev_enable        (saved_prev_enable),
    .saved_prev_priv          (saved_prev_priv)
  );

  always #6 clk = ~clk;

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        trap_board.log_check_event({current_pc, priv_mode, asleep, machine_global_enable,
                                    supervisor_global_enable, raise_lines, device_request});
      if (out_valid && !out_stall)
        trap_board.check_trap_result({trap_taken, cause_code, to_supervisor, target_pc,
                                      new_priv, saved_pc, saved_prev_enable,
                                      saved_prev_priv});
    end
  end

  // Stall the output on a pattern that switches style at random
  int unsigned stall_left = 0;
  int unsigned stall_style = 0;
  int unsigned stall_tick = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 80);
    end
    stall_left--;
    stall_tick++;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 5) < 2;
    endcase
  end

  function automatic check_event_t mk_event(logic [XLEN-1:0] pc, logic [1:0] mode,
                                            logic sleep, logic mgie, logic sgie,
                                            logic [PEND_W-1:0] raise, logic dev);
    check_event_t ev;
    ev.pc = pc;
    ev.mode = mode;
    ev.sleep = sleep;
    ev.mgie = mgie;
    ev.sgie = sgie;
    ev.raise = raise;
    ev.dev = dev;
    return ev;
  endfunction

  function automatic logic [XLEN-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Sparse raise lines keep the pending store from saturating
  function automatic check_event_t random_event();
    int unsigned       pick;
    logic [PEND_W-1:0] raise;
    pick = $urandom_range(0, 9);
    if (pick < 5) raise = '0;
    else if (pick < 8) raise = PEND_W'(1) << $urandom_range(0, PEND_W - 1);
    else raise = PEND_W'($urandom);
    return mk_event(rand_word(), 2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0,
                    1'($urandom), 1'($urandom), raise, $urandom_range(0, 3) == 0);
  endfunction

  function automatic logic [PEND_W-1:0] rand_mask();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return PEND_W'($urandom);
    endcase
  endfunction

  function automatic logic [XLEN-1:0] rand_vector();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return rand_word();
    endcase
  endfunction

  // Present one item and hold it until the block takes it
  task automatic send_event(check_event_t ev);
    @(negedge clk);
    in_valid = 1'b1;
    current_pc = ev.pc;
    priv_mode = ev.mode;
    asleep = ev.sleep;
    machine_global_enable = ev.mgie;
    supervisor_global_enable = ev.sgie;
    raise_lines = ev.raise;
    device_request = ev.dev;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_input(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drain();
    idle_input(1);
    while (trap_board.expected_traps.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [XLEN-1:0] value);
    @(negedge clk);
    config_write = 1'b1;
    config_index = index;
    config_data = value;
    @(negedge clk);
    config_write = 1'b0;
    trap_board.write_reg(index, value);
  endtask

  task automatic set_config(logic [PEND_W-1:0] enables, logic [PEND_W-1:0] delegs,
                            logic [XLEN-1:0] mvec, logic [XLEN-1:0] svec);
    write_reg(REG_ENABLE_MASK, {{(XLEN-PEND_W){1'b0}}, enables});
    write_reg(REG_DELEGATE_MASK, {{(XLEN-PEND_W){1'b0}}, delegs});
    write_reg(REG_MACHINE_VEC, mvec);
    write_reg(REG_SUPER_VEC, svec);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: all causes enabled, none delegated, machine base vectored at the top
    set_config('1, '0, '1, 64'h0000_0000_8000_0000);
    send_event(mk_event('1, MODE_MACHINE, 1'b0, 1'b1, 1'b0, '1, 1'b0));
    // Drain the remaining causes in priority order, then leave only even bits
    repeat (6) send_event(mk_event('0, MODE_MACHINE, 1'b0, 1'b1, 1'b1, '0, 1'b0));
    // Machine gate closed: raise is kept, device request is dropped
    send_event(mk_event(rand_word(), MODE_MACHINE, 1'b0, 1'b0, 1'b1, 12'h008, 1'b1));
    // Asleep bypasses the closed gate
    send_event(mk_event(rand_word(), MODE_MACHINE, 1'b1, 1'b0, 1'b0, '0, 1'b0));
    send_event(mk_event(rand_word(), MODE_SUPER, 1'b0, 1'b1, 1'b0, 12'h020, 1'b1));
    send_event(mk_event(rand_word(), MODE_SUPER, 1'b0, 1'b0, 1'b1, '0, 1'b1));
    send_event(mk_event(rand_word(), MODE_USER, 1'b0, 1'b0, 1'b0, '0, 1'b0));
    send_event(mk_event(rand_word(), MODE_RESERVED, 1'b0, 1'b0, 1'b0, 12'h080, 1'b0));
    wait_drain();

    // Directed: everything delegated, supervisor base vectored at the top
    set_config('1, '1, '0, '1);
    send_event(mk_event(rand_word(), MODE_USER, 1'b0, 1'b0, 1'b1, 12'hAAA, 1'b0));
    send_event(mk_event(rand_word(), MODE_SUPER, 1'b0, 1'b0, 1'b1, '0, 1'b0));
    send_event(mk_event(rand_word(), MODE_SUPER, 1'b1, 1'b1, 1'b0, '0, 1'b0));
    send_event(mk_event(rand_word(), MODE_MACHINE, 1'b0, 1'b1, 1'b1, '0, 1'b0));
    send_event(mk_event(rand_word(), MODE_RESERVED, 1'b0, 1'b1, 1'b0, '0, 1'b0));
    send_event(mk_event(rand_word(), MODE_USER, 1'b0, 1'b0, 1'b0, '0, 1'b0));
    send_event(mk_event(rand_word(), MODE_USER, 1'b0, 1'b1, 1'b1, 12'h555, 1'b1));
    send_event(mk_event(rand_word(), MODE_USER, 1'b0, 1'b1, 1'b1, '0, 1'b0));

    // Random phases; the first few pin the register extremes
    for (int unsigned p = 0; p < PHASES; p++) begin
      wait_drain();
      case (p)
        0: set_config('1, '0, '0, '1);
        1: set_config('1, '1, '1, rand_word() | 64'h1);
        2: set_config('0, rand_mask(), rand_word(), rand_word());
        default: set_config(rand_mask(), rand_mask(), rand_vector(), rand_vector());
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int unsigned b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
          send_event(random_event());
          sent++;
        end
        if ($urandom_range(0, 2) == 0) idle_input($urandom_range(1, 6));
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d check events across %0d config phases plus directed cases",
             trap_board.events_seen, PHASES);
    $display("Traps entered: %0d, of which %0d went to supervisor mode",
             trap_board.traps_seen, trap_board.super_traps);
    if (trap_board.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", trap_board.failures);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", trap_board.expected_traps.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
